### hdl/rcsmd_pkg.sv
// Package for the RC stick and mode-switch decoder.
// Request and response payload types, controller/datapath link types, constants.
// No dependencies.
`timescale 1ns / 1ps

package rcsmd_pkg;

   // Request payload: one RC frame of pulse widths in microseconds
   typedef struct packed {
      logic [4:0]  channel_count;
      logic [11:0] stick_raw_0;
      logic [11:0] stick_raw_1;
      logic [11:0] stick_raw_2;
      logic [11:0] stick_raw_3;
      logic [11:0] mode_raw;
      logic [11:0] gear_raw;
      logic [11:0] reboot_raw;
   } req_type;

   // Response payload
   typedef struct packed {
      logic               frame_valid;
      logic               hover_active;
      logic               hover_entered;
      logic               command_active;
      logic               command_entered;
      logic               reboot_toggle;
      logic signed [15:0] stick_out_0;
      logic signed [15:0] stick_out_1;
      logic signed [15:0] stick_out_2;
      logic signed [15:0] stick_out_3;
      logic               sticks_centred;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       capture;    // latch the request, clear range error
      logic       setup;      // prepare stick stick_idx
      logic       div_step;   // two quotient bits
      logic       div_store;  // write finished quotient to stick store
      logic       commit;     // update switch state, load response
      logic [1:0] stick_idx;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic short_frame;
      logic need_div;
      logic out_free;
   } dp_status_type;

   // CSR indexes
   localparam logic [1:0] CSR_DEAD_ZONE     = 2'd0;
   localparam logic [1:0] CSR_MODE_THRESH   = 2'd1;
   localparam logic [1:0] CSR_GEAR_THRESH   = 2'd2;
   localparam logic [1:0] CSR_REBOOT_THRESH = 2'd3;

   localparam logic [12:0] CENTRE_US      = 13'd1500;
   localparam logic [9:0]  HALF_SPAN_US   = 10'd500;
   localparam logic [8:0]  DEAD_ZONE_MAX  = 9'd450;
   localparam logic [11:0] SWITCH_MAX_US  = 12'd2100;
   localparam logic [4:0]  MIN_CHANNELS   = 5'd8;
   localparam logic [1:0]  LAST_STICK     = 2'd3;
   localparam logic [2:0]  DIV_LAST_STEP  = 3'd7;

   localparam logic [8:0]  DEAD_ZONE_RST  = 9'd125;
   localparam logic [10:0] MODE_THR_RST   = 11'd1750;
   localparam logic [10:0] GEAR_THR_RST   = 11'd1750;
   localparam logic [10:0] REBOOT_THR_RST = 11'd1500;

   localparam logic [15:0] STICK_POS_SAT  = 16'h7FFF;
   localparam logic [15:0] STICK_NEG_SAT  = 16'h8000;

endpackage

### hdl/rc_stick_mode_switch_decoder_unit.sv
// Top level of the RC stick and mode-switch decoder.
// Instantiates rcsmd_ctrl and rcsmd_datapath; uses rcsmd_pkg.
//
//   Port group | Direction | Handshake           | Carries
//   req_*      | in        | req_valid/req_ready | one RC frame (rcsmd_pkg::req_type)
//   rsp_*      | out       | rsp_valid/rsp_ready | decoded frame (rcsmd_pkg::rsp_type)
//   csr_*      | in        | csr_write_en        | index 0..3, 11-bit write data
//
// A full frame is latched, then each stick gets a set-up step and, unless skipped, the
// shared radix-4 divider (two quotient bits per step), then the frame is committed.
// Sticks inside the dead zone or in saturation skip the divider; short frames skip the
// sticks. The next request is taken once the commit is done, even while the previous
// response is still held. Commit waits when the response register is full.
// Reset is synchronous and active high; it loads the CSR defaults and decoder state.
`timescale 1ns / 1ps

module rc_stick_mode_switch_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  rcsmd_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rcsmd_pkg::rsp_type rsp_data,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_index,
   input  logic [10:0]        csr_wdata
);

   rcsmd_pkg::dp_cmd_type    cmd;
   rcsmd_pkg::dp_status_type status;

   // sequencer: latch, four sticks, commit
   rcsmd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // CSRs, stick divider, switch logic and the response register
   rcsmd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

### hdl/rcsmd_ctrl.sv
// Controller for the RC decoder: sequences capture, four stick divisions and commit.
// Depends on rcsmd_pkg.
`timescale 1ns / 1ps

module rcsmd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rcsmd_pkg::dp_status_type status,
   output rcsmd_pkg::dp_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SETUP  = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] idx_ff, idx_in;
   logic [2:0] cnt_ff, cnt_in;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.stick_idx = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (status.short_frame) begin
               state_in = ST_COMMIT;
            end else begin
               cmd.setup = 1'b1;
               if (status.need_div) begin
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else if (idx_ff == rcsmd_pkg::LAST_STICK) begin
                  state_in = ST_COMMIT;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 3'd1;
            if (cnt_ff == rcsmd_pkg::DIV_LAST_STEP) begin
               cmd.div_store = 1'b1;
               if (idx_ff == rcsmd_pkg::LAST_STICK) begin
                  state_in = ST_COMMIT;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_COMMIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### hdl/rcsmd_datapath.sv
// Datapath for the RC decoder: CSRs, stick mapping with a radix-4 divider,
// switch edge logic, stick store and response register.
// Depends on rcsmd_pkg.
`timescale 1ns / 1ps

module rcsmd_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  rcsmd_pkg::req_type       req_data,
   input  logic                     csr_write_en,
   input  logic [1:0]               csr_index,
   input  logic [10:0]              csr_wdata,
   input  rcsmd_pkg::dp_cmd_type    cmd,
   output rcsmd_pkg::dp_status_type status,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rcsmd_pkg::rsp_type       rsp_data
);

   // CSRs
   logic [8:0]  dz_cfg_ff;
   logic [10:0] mode_thr_ff, gear_thr_ff, reboot_thr_ff;

   // captured request
   rcsmd_pkg::req_type req_ff;

   // decoder state
   logic [15:0] stick_ff [4];
   logic [11:0] prev_mode_ff, prev_gear_ff, prev_reboot_ff;
   logic        seeded_ff, hover_ff, command_ff, hold_ff;
   logic        bad_ff, bad_in;

   // divider
   logic [8:0]  rem_ff, rem_in;
   logic [15:0] low_ff, low_in;
   logic [15:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;

   // response register
   logic               rsp_valid_ff, rsp_valid_in;
   rcsmd_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // ---- stick set-up ----
   logic [8:0]  dz;
   logic [8:0]  den;
   logic [12:0] raw13, thr_hi, low_sum;
   logic [11:0] raw_sel, mag;
   logic        is_pos, is_neg, nonzero, range_bad, sat;
   logic [15:0] mag_x10, den_x11;
   logic [25:0] num;
   logic [15:0] imm_val;

   always_comb begin
      dz  = (dz_cfg_ff > rcsmd_pkg::DEAD_ZONE_MAX) ? rcsmd_pkg::DEAD_ZONE_MAX : dz_cfg_ff;
      den = 9'(rcsmd_pkg::HALF_SPAN_US - {1'b0, dz});
      case (cmd.stick_idx)
         2'd0:    raw_sel = req_ff.stick_raw_0;
         2'd1:    raw_sel = req_ff.stick_raw_1;
         2'd2:    raw_sel = req_ff.stick_raw_2;
         default: raw_sel = req_ff.stick_raw_3;
      endcase
      raw13   = {1'b0, raw_sel};
      thr_hi  = rcsmd_pkg::CENTRE_US + {4'd0, dz};
      low_sum = raw13 + {4'd0, dz};
      is_pos  = raw13 > thr_hi;
      is_neg  = low_sum < rcsmd_pkg::CENTRE_US;
      if (is_pos) begin
         mag = 12'(raw13 - thr_hi);
      end else if (is_neg) begin
         mag = 12'(rcsmd_pkg::CENTRE_US - low_sum);
      end else begin
         mag = '0;
      end
      nonzero   = is_pos | is_neg;
      mag_x10   = {1'b0, mag, 3'd0} + {3'd0, mag, 1'b0};
      den_x11   = {4'd0, den, 3'd0} + {6'd0, den, 1'b0} + {7'd0, den};
      range_bad = nonzero && (mag_x10 > den_x11);
      // rounded numerator; quotient saturates once it reaches 2^15
      num     = {mag, 14'd0} + {18'd0, den[8:1]};
      sat     = num >= {2'd0, den, 15'd0};
      if (!nonzero) begin
         imm_val = '0;
      end else if (is_neg) begin
         imm_val = rcsmd_pkg::STICK_NEG_SAT;
      end else begin
         imm_val = rcsmd_pkg::STICK_POS_SAT;
      end
   end

   // ---- divider: two restoring steps per cycle ----
   logic [9:0] r1, r2;
   logic [8:0] r1s, r2s;
   logic       b1, b2;
   logic [15:0] div_val;

   always_comb begin
      r1     = {rem_ff, low_ff[15]};
      b1     = r1 >= {1'b0, den};
      r1s    = b1 ? 9'(r1 - {1'b0, den}) : r1[8:0];
      r2     = {r1s, low_ff[14]};
      b2     = r2 >= {1'b0, den};
      r2s    = b2 ? 9'(r2 - {1'b0, den}) : r2[8:0];
      rem_in = rem_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      if (cmd.setup) begin
         rem_in = num[24:16];
         low_in = num[15:0];
         quo_in = '0;
         neg_in = is_neg;
      end else if (cmd.div_step) begin
         rem_in = r2s;
         low_in = {low_ff[13:0], 2'd0};
         quo_in = {quo_ff[13:0], b1, b2};
      end
      div_val = neg_ff ? 16'(-quo_in) : quo_in;
   end

   always_comb begin
      bad_in = bad_ff;
      if (cmd.capture) begin
         bad_in = 1'b0;
      end else if (cmd.setup && range_bad) begin
         bad_in = 1'b1;
      end
   end

   // ---- switch logic at commit ----
   logic        short_frame;
   logic [11:0] pm, pg, pr;
   logic [11:0] mode_thr, gear_thr, reboot_thr;
   logic        hover_in, command_in, hold_in, hover_edge, toggle, valid;
   logic        centred;

   always_comb begin
      short_frame = req_ff.channel_count < rcsmd_pkg::MIN_CHANNELS;
      mode_thr    = {1'b0, mode_thr_ff};
      gear_thr    = {1'b0, gear_thr_ff};
      reboot_thr  = {1'b0, reboot_thr_ff};
      pm = seeded_ff ? prev_mode_ff   : req_ff.mode_raw;
      pg = seeded_ff ? prev_gear_ff   : req_ff.gear_raw;
      pr = seeded_ff ? prev_reboot_ff : req_ff.reboot_raw;
      hover_in   = hover_ff;
      command_in = command_ff;
      hold_in    = hold_ff;
      hover_edge = 1'b0;
      toggle     = 1'b0;
      valid      = 1'b0;
      if (short_frame) begin
         hold_in = 1'b0;
      end else begin
         valid = !bad_ff && (req_ff.mode_raw <= rcsmd_pkg::SWITCH_MAX_US)
                 && (req_ff.gear_raw <= rcsmd_pkg::SWITCH_MAX_US)
                 && (req_ff.reboot_raw <= rcsmd_pkg::SWITCH_MAX_US);
         hover_edge = (pm < mode_thr) && (req_ff.mode_raw > mode_thr);
         hover_in   = req_ff.mode_raw > mode_thr;
         if (hover_in) begin
            if ((pg < gear_thr) && (req_ff.gear_raw > gear_thr)) begin
               hold_in = 1'b1;
            end else if (req_ff.gear_raw < gear_thr) begin
               hold_in = 1'b0;
            end
            command_in = req_ff.gear_raw > gear_thr;
         end
         toggle = !hover_in && !command_in && (pr < reboot_thr)
                  && (req_ff.reboot_raw > reboot_thr);
      end
      centred = (stick_ff[0] == '0) && (stick_ff[1] == '0)
                && (stick_ff[2] == '0) && (stick_ff[3] == '0);

      rsp_data_in.frame_valid     = valid;
      rsp_data_in.hover_active    = hover_in;
      rsp_data_in.hover_entered   = hover_edge;
      rsp_data_in.command_active  = command_in;
      rsp_data_in.command_entered = hold_in;
      rsp_data_in.reboot_toggle   = toggle;
      rsp_data_in.stick_out_0     = stick_ff[0];
      rsp_data_in.stick_out_1     = stick_ff[1];
      rsp_data_in.stick_out_2     = stick_ff[2];
      rsp_data_in.stick_out_3     = stick_ff[3];
      rsp_data_in.sticks_centred  = centred;

      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign status.short_frame = short_frame;
   assign status.need_div    = nonzero && !sat;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         dz_cfg_ff      <= rcsmd_pkg::DEAD_ZONE_RST;
         mode_thr_ff    <= rcsmd_pkg::MODE_THR_RST;
         gear_thr_ff    <= rcsmd_pkg::GEAR_THR_RST;
         reboot_thr_ff  <= rcsmd_pkg::REBOOT_THR_RST;
         stick_ff[0]    <= '0;
         stick_ff[1]    <= '0;
         stick_ff[2]    <= '0;
         stick_ff[3]    <= '0;
         prev_mode_ff   <= '0;
         prev_gear_ff   <= '0;
         prev_reboot_ff <= '0;
         seeded_ff      <= 1'b0;
         hover_ff       <= 1'b1;
         command_ff     <= 1'b1;
         hold_ff        <= 1'b0;
         bad_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               rcsmd_pkg::CSR_DEAD_ZONE:     dz_cfg_ff     <= csr_wdata[8:0];
               rcsmd_pkg::CSR_MODE_THRESH:   mode_thr_ff   <= csr_wdata;
               rcsmd_pkg::CSR_GEAR_THRESH:   gear_thr_ff   <= csr_wdata;
               rcsmd_pkg::CSR_REBOOT_THRESH: reboot_thr_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.setup && !(nonzero && !sat)) begin
            stick_ff[cmd.stick_idx] <= imm_val;
         end else if (cmd.div_store) begin
            stick_ff[cmd.stick_idx] <= div_val;
         end
         if (cmd.commit) begin
            hover_ff   <= hover_in;
            command_ff <= command_in;
            hold_ff    <= hold_in;
            if (!short_frame) begin
               seeded_ff      <= 1'b1;
               prev_mode_ff   <= req_ff.mode_raw;
               prev_gear_ff   <= req_ff.gear_raw;
               prev_reboot_ff <= req_ff.reboot_raw;
            end
         end
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
      if (cmd.commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
